// ===== sv/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab slot allocator package
// Shared constants, codes and types for the slab slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int SLOTS_PER_FRAME_DEF = 32;
    localparam int MAX_BLOCKS_DEF      = 8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // One request as it travels from the front end to the back end.
    typedef struct packed {
        logic       kind;
        logic [2:0] block_frame;
        logic [4:0] slot_index;
    } req_t;

    // One finished result.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] granted_frame;
        logic [4:0] granted_slot;
        logic       frame_released;
    } rsp_t;

endpackage

// ===== sv/ssa_front.sv =====
// ----------------------------------------------------------------------------
// Slab slot allocator front end
// Accepts requests into a two-entry queue that feeds the back end.
// ----------------------------------------------------------------------------
module ssa_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ssa_pkg::req_t in_req,
    output logic          q_valid,
    input  logic          q_pop,
    output ssa_pkg::req_t q_req
);

    ssa_pkg::req_t mem_reg [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;
    logic          push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ===== sv/ssa_back.sv =====
// ----------------------------------------------------------------------------
// Slab slot allocator back end
// Sequencer that walks the frame list, searches slots and updates state.
// ----------------------------------------------------------------------------
module ssa_back
#(
    parameter int SLOTS_PER_FRAME = ssa_pkg::SLOTS_PER_FRAME_DEF,
    parameter int MAX_BLOCKS      = ssa_pkg::MAX_BLOCKS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [5:0]    items_per_block,
    input  logic          q_valid,
    output logic          q_pop,
    input  ssa_pkg::req_t q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output ssa_pkg::rsp_t out_rsp
);

    localparam int FW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam int CW = $clog2(SLOTS_PER_FRAME + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SLOT  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [SLOTS_PER_FRAME-1:0] map_reg   [MAX_BLOCKS];
    logic [CW-1:0]              count_reg [MAX_BLOCKS];
    logic [FW-1:0]              order_reg [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]      active_reg;
    logic [LW-1:0]              len_reg;

    logic [2:0]    state_reg;
    ssa_pkg::req_t req_reg;
    logic [LW-1:0] pos_reg;
    logic [FW-1:0] fr_reg;
    logic [SW:0]   sl_reg;
    ssa_pkg::rsp_t work_reg;
    ssa_pkg::rsp_t rsp_reg;
    logic          ovalid_reg;

    logic [CW-1:0] lim;
    logic [FW-1:0] cur_f;
    logic [FW-1:0] free_f;
    logic          free_any;
    logic [FW-1:0] req_f;
    logic          req_f_ok;
    logic          req_s_ok;
    logic [SW-1:0] req_s;

    always_comb
    begin
        if (items_per_block == 6'd0)
        begin
            lim = CW'(1);
        end
        else if (32'(items_per_block) > SLOTS_PER_FRAME)
        begin
            lim = CW'(SLOTS_PER_FRAME);
        end
        else
        begin
            lim = CW'(items_per_block);
        end
    end

    assign cur_f    = order_reg[pos_reg[FW-1:0]];
    assign req_f    = FW'(req_reg.block_frame);
    assign req_f_ok = (32'(req_reg.block_frame) < MAX_BLOCKS);
    assign req_s_ok = (32'(req_reg.slot_index) < SLOTS_PER_FRAME);
    assign req_s    = SW'(req_reg.slot_index);

    always_comb
    begin
        free_f   = '0;
        free_any = 1'b0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_f   = FW'(i);
                free_any = 1'b1;
            end
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = ovalid_reg;
    assign out_rsp   = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                map_reg[i]   <= '0;
                count_reg[i] <= '0;
                order_reg[i] <= '0;
            end
            active_reg <= MAX_BLOCKS'(1);
            len_reg    <= LW'(1);
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            fr_reg     <= '0;
            sl_reg     <= '0;
            work_reg   <= '0;
            rsp_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            // The output register loads only when it is empty or being drained.
            if (state_reg == S_DONE && (!ovalid_reg || out_ready))
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        pos_reg   <= '0;
                        sl_reg    <= '0;
                        state_reg <= (q_req.kind == ssa_pkg::KIND_ALLOC) ? S_WALK : S_SLOT;
                    end
                end
                S_WALK:
                begin
                    if (pos_reg < len_reg && 32'(pos_reg) < MAX_BLOCKS)
                    begin
                        if (count_reg[cur_f] < lim)
                        begin
                            fr_reg    <= cur_f;
                            state_reg <= S_SLOT;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + LW'(1);
                        end
                    end
                    else
                    begin
                        if (32'(len_reg) >= MAX_BLOCKS || !free_any)
                        begin
                            work_reg <= {ssa_pkg::ST_NOSPACE, 3'd0, 5'd0, 1'b0};
                        end
                        else
                        begin
                            active_reg[free_f] <= 1'b1;
                            map_reg[free_f]    <= SLOTS_PER_FRAME'(1);
                            count_reg[free_f]  <= CW'(1);
                            order_reg[len_reg[FW-1:0]] <= free_f;
                            len_reg  <= len_reg + LW'(1);
                            work_reg <= {ssa_pkg::ST_OK, 3'(free_f), 5'd0, 1'b0};
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_SLOT:
                begin
                    if (req_reg.kind == ssa_pkg::KIND_ALLOC)
                    begin
                        // One slot tested per cycle, lowest first.
                        if (32'(sl_reg) >= 32'(lim))
                        begin
                            work_reg  <= {ssa_pkg::ST_NOSPACE, 3'd0, 5'd0, 1'b0};
                            state_reg <= S_DONE;
                        end
                        else if (!map_reg[fr_reg][sl_reg[SW-1:0]])
                        begin
                            map_reg[fr_reg][sl_reg[SW-1:0]] <= 1'b1;
                            count_reg[fr_reg] <= count_reg[fr_reg] + CW'(1);
                            work_reg  <= {ssa_pkg::ST_OK, 3'(fr_reg), 5'(sl_reg), 1'b0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            sl_reg <= sl_reg + (SW+1)'(1);
                        end
                    end
                    else
                    begin
                        if (!req_f_ok || !req_s_ok || !active_reg[req_f]
                            || !map_reg[req_f][req_s])
                        begin
                            work_reg  <= {ssa_pkg::ST_INVALID, 3'd0, 5'd0, 1'b0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            count_reg[req_f] <= (count_reg[req_f] != '0)
                                ? count_reg[req_f] - CW'(1) : '0;
                            if (count_reg[req_f] <= CW'(1) && req_f != '0)
                            begin
                                active_reg[req_f] <= 1'b0;
                                map_reg[req_f]    <= '0;
                                work_reg  <= {ssa_pkg::ST_OK, 3'd0, 5'd0, 1'b1};
                                pos_reg   <= LW'(1);
                                fr_reg    <= req_f;
                                state_reg <= S_SHIFT;
                            end
                            else
                            begin
                                map_reg[req_f][req_s] <= 1'b0;
                                work_reg  <= {ssa_pkg::ST_OK, 3'd0, 5'd0, 1'b0};
                                state_reg <= S_DONE;
                            end
                        end
                    end
                end
                S_SHIFT:
                begin
                    // Find the frame in the list, then close the gap one entry a cycle.
                    if (pos_reg >= len_reg || 32'(pos_reg) >= MAX_BLOCKS)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (order_reg[pos_reg[FW-1:0]] == fr_reg || sl_reg[0])
                    begin
                        sl_reg[0] <= 1'b1;
                        if (32'(pos_reg) + 1 < 32'(len_reg) && 32'(pos_reg) + 1 < MAX_BLOCKS)
                        begin
                            order_reg[pos_reg[FW-1:0]] <= order_reg[FW'(pos_reg + LW'(1))];
                            pos_reg <= pos_reg + LW'(1);
                        end
                        else
                        begin
                            order_reg[FW'(len_reg - LW'(1))] <= '0;
                            len_reg   <= len_reg - LW'(1);
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        pos_reg <= pos_reg + LW'(1);
                    end
                end
                S_DONE:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        rsp_reg   <= work_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/slab_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Slab slot allocator core
// Fixed-size slot allocator over a list of block frames.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  input     in_valid / in_ready     kind, block_frame, slot_index
//  output    out_valid / out_ready   status, granted_frame, granted_slot,
//                                    frame_released
//  config    cfg_we                  cfg_data (items_per_block)
//
// An allocate walks the list past each full frame, then tests the slots of
// the first frame that is not full, lowest first, until one is free or the
// limit is reached; if all listed frames are full it appends a new frame.
// The back end's sequencer runs these steps. A free that empties any frame
// but frame 0 unlinks it. Reset clears all state to a single empty frame 0
// at once. A two-entry queue decouples input transfers from the back end,
// and the output register holds a result while the next item is taken in.
// ----------------------------------------------------------------------------
module slab_slot_allocator_core
#(
    parameter int SLOTS_PER_FRAME = ssa_pkg::SLOTS_PER_FRAME_DEF,
    parameter int MAX_BLOCKS      = ssa_pkg::MAX_BLOCKS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [2:0] block_frame,
    input  logic [4:0] slot_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [2:0] granted_frame,
    output logic [4:0] granted_slot,
    output logic       frame_released
);

    logic [5:0]    ipb_reg;
    ssa_pkg::req_t in_req;
    ssa_pkg::req_t q_req;
    ssa_pkg::rsp_t rsp;
    logic          q_valid;
    logic          q_pop;

    // Slot limit register; the user writes it only while idle (unenforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipb_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            ipb_reg <= cfg_data;
        end
    end

    assign in_req.kind        = kind;
    assign in_req.block_frame = block_frame;
    assign in_req.slot_index  = slot_index;

    ssa_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    ssa_back #(
        .SLOTS_PER_FRAME (SLOTS_PER_FRAME),
        .MAX_BLOCKS      (MAX_BLOCKS)
    ) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .items_per_block (ipb_reg),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_req           (q_req),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_rsp         (rsp)
    );

    assign status         = rsp.status;
    assign granted_frame  = rsp.granted_frame;
    assign granted_slot   = rsp.granted_slot;
    assign frame_released = rsp.frame_released;

endmodule

// ===== verif/slab_slot_allocator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slab slot allocator checker
// Watches the request, result and register ports of the allocator, keeps
// its own picture of the frame list and slot maps, and compares every result
// transfer with the result that picture predicts.
// ----------------------------------------------------------------------------
module slab_slot_allocator_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       kind,
    input  logic [2:0] block_frame,
    input  logic [4:0] slot_index,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] status,
    input  logic [2:0] granted_frame,
    input  logic [4:0] granted_slot,
    input  logic       frame_released,
    output int         fail_count,
    output int         pending,
    output int         nospace_seen,
    output int         released_seen
);

    localparam int NSLOT  = ssa_pkg::SLOTS_PER_FRAME_DEF;
    localparam int NFRAME = ssa_pkg::MAX_BLOCKS_DEF;

    logic [NSLOT-1:0] slot_map   [NFRAME];
    int               used_slots [NFRAME];
    int               chain      [NFRAME];
    logic             linked     [NFRAME];
    int               chain_len;
    logic [5:0]       slots_per_block;
    ssa_pkg::rsp_t    expected_rsp [$];

    function automatic ssa_pkg::rsp_t make_rsp(logic [1:0] st, int fr, int sl, logic rel);
        ssa_pkg::rsp_t r;
        r.status         = st;
        r.granted_frame  = fr[2:0];
        r.granted_slot   = sl[4:0];
        r.frame_released = rel;
        return r;
    endfunction

    function automatic int usable_slots();
        int n;
        n = slots_per_block;
        if (n == 0) n = 1;
        if (n > NSLOT) n = NSLOT;
        return n;
    endfunction

    // The search stops at the first frame that is not full, even if that frame
    // has no free slot below the limit.
    function automatic ssa_pkg::rsp_t grant_slot();
        int lim;
        int f;
        lim = usable_slots();
        for (int p = 0; p < chain_len; p++) begin
            f = chain[p];
            if (used_slots[f] < lim) begin
                for (int s = 0; s < lim; s++) begin
                    if (!slot_map[f][s]) begin
                        slot_map[f][s] = 1'b1;
                        used_slots[f]++;
                        return make_rsp(ssa_pkg::ST_OK, f, s, 1'b0);
                    end
                end
                return make_rsp(ssa_pkg::ST_NOSPACE, 0, 0, 1'b0);
            end
        end
        if (chain_len >= NFRAME) return make_rsp(ssa_pkg::ST_NOSPACE, 0, 0, 1'b0);
        for (int g = 0; g < NFRAME; g++) begin
            if (!linked[g]) begin
                linked[g]         = 1'b1;
                slot_map[g]       = '0;
                slot_map[g][0]    = 1'b1;
                used_slots[g]     = 1;
                chain[chain_len]  = g;
                chain_len++;
                return make_rsp(ssa_pkg::ST_OK, g, 0, 1'b0);
            end
        end
        return make_rsp(ssa_pkg::ST_NOSPACE, 0, 0, 1'b0);
    endfunction

    function automatic ssa_pkg::rsp_t release_slot(int f, int s);
        if (!linked[f] || !slot_map[f][s]) return make_rsp(ssa_pkg::ST_INVALID, 0, 0, 1'b0);
        slot_map[f][s] = 1'b0;
        if (used_slots[f] > 0) used_slots[f]--;
        if (used_slots[f] == 0 && f != 0) begin
            for (int p = 1; p < chain_len; p++) begin
                if (chain[p] == f) begin
                    for (int k = p; k + 1 < chain_len; k++) chain[k] = chain[k + 1];
                    chain_len--;
                    chain[chain_len] = 0;
                    break;
                end
            end
            linked[f]   = 1'b0;
            slot_map[f] = '0;
            return make_rsp(ssa_pkg::ST_OK, 0, 0, 1'b1);
        end
        return make_rsp(ssa_pkg::ST_OK, 0, 0, 1'b0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ssa_pkg::rsp_t want;
        if (!rst_n) begin
            for (int i = 0; i < NFRAME; i++) begin
                slot_map[i]   = '0;
                used_slots[i] = 0;
                chain[i]      = 0;
                linked[i]     = (i == 0);
            end
            chain_len       = 1;
            slots_per_block = 6'd32;
            expected_rsp.delete();
            fail_count    = 0;
            nospace_seen  = 0;
            released_seen = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: result transfer with none expected, got %0d/%0d/%0d/%0d",
                             $time, status, granted_frame, granted_slot, frame_released);
                    fail_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        fail_count++;
                    end
                    if (granted_frame !== want.granted_frame) begin
                        $display("%0t: granted_frame expected %0d actual %0d",
                                 $time, want.granted_frame, granted_frame);
                        fail_count++;
                    end
                    if (granted_slot !== want.granted_slot) begin
                        $display("%0t: granted_slot expected %0d actual %0d",
                                 $time, want.granted_slot, granted_slot);
                        fail_count++;
                    end
                    if (frame_released !== want.frame_released) begin
                        $display("%0t: frame_released expected %0d actual %0d",
                                 $time, want.frame_released, frame_released);
                        fail_count++;
                    end
                    if (want.status == ssa_pkg::ST_NOSPACE) nospace_seen++;
                    if (want.frame_released) released_seen++;
                end
            end
            if (in_valid && in_ready) begin
                if (kind == ssa_pkg::KIND_ALLOC) want = grant_slot();
                else                             want = release_slot(block_frame, slot_index);
                expected_rsp.push_back(want);
            end
            if (cfg_we) slots_per_block = cfg_data;
        end
        pending = expected_rsp.size();
    end

endmodule

// ===== verif/slab_slot_allocator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slab slot allocator testbench
// Drives allocate and free requests through several slot-per-frame settings,
// with random gaps and back-pressure, and lets the checker score each result.
// ----------------------------------------------------------------------------
module slab_slot_allocator_core_tb;

    // A generous ceiling: the slowest allocate walks eight frames and 32 slots.
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 60;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [5:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic       kind;
    logic [2:0] block_frame;
    logic [4:0] slot_index;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [2:0] granted_frame;
    logic [4:0] granted_slot;
    logic       frame_released;

    int fail_count;
    int pending;
    int nospace_seen;
    int released_seen;

    int  cycles;
    bit  quiet;           // set for the final stretch: no gaps, no stalls
    int  hold_requests;   // bumped by the stimulus to ask for one long stall
    int  holds_served;
    int  alloc_sent;
    int  free_sent;
    int  slot_span;       // upper bound of slot numbers used for frees

    slab_slot_allocator_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .block_frame    (block_frame),
        .slot_index     (slot_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_frame  (granted_frame),
        .granted_slot   (granted_slot),
        .frame_released (frame_released)
    );

    slab_slot_allocator_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .block_frame    (block_frame),
        .slot_index     (slot_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_frame  (granted_frame),
        .granted_slot   (granted_slot),
        .frame_released (frame_released),
        .fail_count     (fail_count),
        .pending        (pending),
        .nospace_seen   (nospace_seen),
        .released_seen  (released_seen)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog. If the block hangs, the run ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side. Short random stalls during most of the run; on request a
    // long stall so the input queue fills and in_ready drops.
    always @(posedge clk or negedge rst_n)
    begin
        int hold_left;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = 120;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Offers one request and returns at the edge where it is transferred.
    // Valid is lowered only when a gap is taken, so it gets one assignment
    // per time step even when requests go back to back.
    task automatic offer(logic k, logic [2:0] f, logic [4:0] s);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        block_frame <= f;
        slot_index  <= s;
        do @(posedge clk); while (!in_ready);
        if (k == ssa_pkg::KIND_ALLOC) alloc_sent++;
        else                          free_sent++;
    endtask

    // Register writes happen only with the block idle: every result is back,
    // and a margin covers any unlink still running inside.
    task automatic set_slots_per_block(logic [5:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (v == 0)       slot_span = 1;
        else if (v > 32)  slot_span = 32;
        else              slot_span = v;
    endtask

    // Mostly allocates and frees of slots that are likely live, with a share
    // of fully random frees that land on idle frames and unused slots.
    task automatic random_phase(int count);
        logic [4:0] s;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 52) begin
                offer(ssa_pkg::KIND_ALLOC, 3'($urandom), 5'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
                offer(ssa_pkg::KIND_FREE, 3'($urandom), 5'($urandom));
            end else begin
                s = 5'($urandom_range(0, slot_span - 1));
                offer(ssa_pkg::KIND_FREE, 3'($urandom_range(0, 7)), s);
            end
        end
    endtask

    initial
    begin
        logic [5:0] settings [8];
        cycles        = 0;
        quiet         = 1'b0;
        hold_requests = 0;
        holds_served  = 0;
        alloc_sent    = 0;
        free_sent     = 0;
        slot_span     = 32;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = 6'd0;
        in_valid    = 1'b0;
        kind        = ssa_pkg::KIND_ALLOC;
        block_frame = 3'd0;
        slot_index  = 5'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: two grants in frame 0, a double free, and frame 0
        // emptied, which must keep it linked.
        offer(ssa_pkg::KIND_ALLOC, 3'd7, 5'd31);
        offer(ssa_pkg::KIND_ALLOC, 3'd0, 5'd0);
        offer(ssa_pkg::KIND_FREE,  3'd0, 5'd1);
        offer(ssa_pkg::KIND_FREE,  3'd0, 5'd1);
        offer(ssa_pkg::KIND_FREE,  3'd0, 5'd0);

        // One slot per frame: fill all eight frames and run out of space,
        // then unlink a middle frame and reuse it at the tail.
        set_slots_per_block(6'd1);
        repeat (9) offer(ssa_pkg::KIND_ALLOC, 3'd0, 5'd0);
        offer(ssa_pkg::KIND_FREE,  3'd3, 5'd0);
        offer(ssa_pkg::KIND_FREE,  3'd3, 5'd0);
        offer(ssa_pkg::KIND_FREE,  3'd7, 5'd31);
        offer(ssa_pkg::KIND_ALLOC, 3'd0, 5'd0);
        offer(ssa_pkg::KIND_FREE,  3'd7, 5'd0);
        offer(ssa_pkg::KIND_FREE,  3'd0, 5'd0);
        offer(ssa_pkg::KIND_ALLOC, 3'd0, 5'd0);
        offer(ssa_pkg::KIND_ALLOC, 3'd0, 5'd0);

        // Settings cover the extremes, zero and an over-range value that
        // clamps to the full frame.
        settings = '{6'd32, 6'd2, 6'd0, 6'd63, 6'd7, 6'd1, 6'd4, 6'd3};
        for (int ph = 0; ph < 8; ph++) begin
            set_slots_per_block(ph == 7 ? 6'($urandom) : settings[ph]);
            if (ph == 1) hold_requests++;
            if (ph == 7) quiet = 1'b1;
            random_phase(185);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d allocates and %0d frees over nine register writes,",
                 alloc_sent, free_sent);
        $display("with %0d out-of-space results and %0d frames unlinked.",
                 nospace_seen, released_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results still expected", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
